// ===== hw/rtl/cst_pkg.sv =====
// ----------------------------------------------------------------------------
// cst_pkg
// Shared constants and types for the checkpoint sequence timer.
// ----------------------------------------------------------------------------
`default_nettype none

package cst_pkg;

  // default sizing
  localparam int unsigned MAX_CHECKPOINTS_DEF = 16;
  localparam int unsigned TIME_WIDTH_DEF      = 32;

  // fixed field widths
  localparam int unsigned DELTA_W   = 16;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned ENTRY_W   = 32;
  localparam int unsigned FRAME_W   = 8;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 8;

  // item function codes
  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_LOAD = 1'b1
  } func_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIMER_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHECKPT_CNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_CNT   = 2'd2;

  // timer modes
  localparam logic MODE_ONE_SHOT = 1'b0;
  localparam logic MODE_REPEAT   = 1'b1;

  // one result word
  typedef struct packed {
    logic               pulse;
    logic [FRAME_W-1:0] frame_index;
    logic [SLOT_W-1:0]  checkpoint_index;
    logic               finished;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cst_ram.sv =====
// ----------------------------------------------------------------------------
// cst_ram
// Generic single-write, single-read RAM with registered read data.
// Read returns the contents before a same-cycle write.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hw/rtl/checkpoint_sequence_timer_core.sv =====
// ----------------------------------------------------------------------------
// checkpoint_sequence_timer_core
// Sequence timer over a RAM table of cumulative checkpoint times, driving a
// wrapping frame counter. Tick words advance time, load words fill the table.
// ----------------------------------------------------------------------------
// The result word is written into the result buffer when the input word is accepted.
// Throughput: 1 word per cycle while the result buffer is not full; the table RAM is re-read every cycle at the
//   awaited checkpoint, with a same-cycle write forwarded around the RAM.
// A 2-entry result buffer keeps input flowing while the output stalls, until it is full.
// Reset clears timer state, config and the buffer; table entries are
//   undefined until loaded (no clearing pass).
`default_nettype none

module checkpoint_sequence_timer_core #(
  parameter int unsigned MAX_CHECKPOINTS = cst_pkg::MAX_CHECKPOINTS_DEF,
  parameter int unsigned TIME_WIDTH      = cst_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input words
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_func,
  input  wire logic [cst_pkg::DELTA_W-1:0]       in_delta_ticks,
  input  wire logic [cst_pkg::SLOT_W-1:0]        in_entry_index,
  input  wire logic [cst_pkg::ENTRY_W-1:0]       in_entry_time,
  // result words
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_pulse,
  output logic [cst_pkg::FRAME_W-1:0]            out_frame_index,
  output logic [cst_pkg::SLOT_W-1:0]             out_checkpoint_index,
  output logic                                   out_finished,
  // configuration writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [cst_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [cst_pkg::CFG_DAT_W-1:0]     cfg_data
);

  localparam int unsigned IDX_W = (MAX_CHECKPOINTS > 1) ? $clog2(MAX_CHECKPOINTS) : 1;
  localparam int unsigned SUM_W = ((TIME_WIDTH > cst_pkg::DELTA_W) ?
                                   TIME_WIDTH : cst_pkg::DELTA_W) + 1;
  localparam logic [8:0]  MAX_CP9 = 9'(MAX_CHECKPOINTS);

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  logic                        mode_r;
  logic [cst_pkg::CNT_W-1:0]   cp_cnt_r;
  logic [cst_pkg::FRAME_W-1:0] frm_cnt_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= cst_pkg::MODE_ONE_SHOT;
      cp_cnt_r  <= '0;
      frm_cnt_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cst_pkg::REG_TIMER_MODE:  mode_r    <= cfg_data[0];
        cst_pkg::REG_CHECKPT_CNT: cp_cnt_r  <= cfg_data[cst_pkg::CNT_W-1:0];
        cst_pkg::REG_FRAME_CNT:   frm_cnt_r <= cfg_data[cst_pkg::FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // timer state
  // --------------------------------------------------------------------------
  logic [TIME_WIDTH-1:0]       elapsed_r, elapsed_nxt;
  logic [IDX_W-1:0]            ncp_r, ncp_nxt;
  logic                        done_r, done_nxt;
  logic [cst_pkg::FRAME_W-1:0] frame_r, frame_nxt;

  logic                        in_acc;
  logic [TIME_WIDTH-1:0]       target;
  logic                        pulse;
  logic                        done_rep;

  // table RAM and forwarding
  logic                        tbl_we;
  logic [IDX_W-1:0]            tbl_waddr;
  logic [TIME_WIDTH-1:0]       tbl_wdata;
  logic [TIME_WIDTH-1:0]       tbl_rdata;
  logic                        fwd_vld_r;
  logic [TIME_WIDTH-1:0]       fwd_dat_r;

  logic [8:0]                  slot9;
  logic [63:0]                 etime64;
  logic [SUM_W-1:0]            sum;
  logic [TIME_WIDTH-1:0]       elapsed_add;
  logic [8:0]                  n9;
  logic [8:0]                  ncp_inc9;
  logic [8:0]                  frm_inc9;
  logic [IDX_W-1:0]            ncp_wrap;
  logic [cst_pkg::FRAME_W-1:0] frm_wrap;

  assign in_acc = in_valid && !in_stall;

  // load path
  assign slot9     = {5'b0, in_entry_index};
  assign etime64   = {32'b0, in_entry_time};
  assign tbl_we    = in_acc && (in_func == cst_pkg::FUNC_LOAD) && (slot9 < MAX_CP9);
  assign tbl_waddr = slot9[IDX_W-1:0];
  assign tbl_wdata = etime64[TIME_WIDTH-1:0];

  cst_ram #(
    .WIDTH (TIME_WIDTH),
    .DEPTH (MAX_CHECKPOINTS)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (ncp_nxt),
    .rdata (tbl_rdata)
  );

  // a write hitting the entry being fetched is taken from the bypass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_vld_r <= 1'b0;
    end else begin
      fwd_vld_r <= tbl_we && (tbl_waddr == ncp_nxt);
    end
    fwd_dat_r <= tbl_wdata;
  end

  assign target = fwd_vld_r ? fwd_dat_r : tbl_rdata;

  // saturating add
  assign sum         = SUM_W'(elapsed_r) + SUM_W'(in_delta_ticks);
  assign elapsed_add = (|sum[SUM_W-1:TIME_WIDTH]) ? '1 : sum[TIME_WIDTH-1:0];

  // wrapping increments
  assign n9       = ({4'b0, cp_cnt_r} > MAX_CP9) ? MAX_CP9 : {4'b0, cp_cnt_r};
  assign ncp_inc9 = 9'(ncp_r) + 9'd1;
  assign frm_inc9 = {1'b0, frame_r} + 9'd1;
  assign ncp_wrap = (ncp_inc9 >= n9) ? '0 : ncp_inc9[IDX_W-1:0];
  assign frm_wrap = (frm_inc9 >= {1'b0, frm_cnt_r}) ? '0 : frm_inc9[cst_pkg::FRAME_W-1:0];

  always_comb begin
    elapsed_nxt = elapsed_r;
    ncp_nxt     = ncp_r;
    done_rep    = done_r;
    frame_nxt   = frame_r;
    pulse       = 1'b0;
    if (in_acc && (in_func == cst_pkg::FUNC_TICK) && (frm_cnt_r != '0)) begin
      if (cp_cnt_r == '0) begin
        done_rep = 1'b1;
      end else if (!(mode_r == cst_pkg::MODE_ONE_SHOT && done_r)) begin
        if (elapsed_add < target) begin
          elapsed_nxt = elapsed_add;
        end else begin
          pulse       = 1'b1;
          elapsed_nxt = elapsed_add;
          ncp_nxt     = ncp_wrap;
          frame_nxt   = frm_wrap;
          if (ncp_wrap == '0) begin
            if (mode_r == cst_pkg::MODE_ONE_SHOT) begin
              done_rep = 1'b1;
            end else begin
              elapsed_nxt = '0;
            end
          end
        end
      end
    end
    // repeating mode clears the flag once it has been reported
    done_nxt = (in_acc && mode_r == cst_pkg::MODE_REPEAT) ? 1'b0 : done_rep;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
      ncp_r     <= '0;
      done_r    <= 1'b0;
      frame_r   <= '0;
    end else begin
      elapsed_r <= elapsed_nxt;
      ncp_r     <= ncp_nxt;
      done_r    <= done_nxt;
      frame_r   <= frame_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // result buffer, two words deep
  // --------------------------------------------------------------------------
  cst_pkg::result_t res;
  cst_pkg::result_t buf_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       cnt_r;
  logic             pop;
  logic [8:0]       ncp9;

  assign ncp9                 = 9'(ncp_nxt);
  assign res.pulse            = pulse;
  assign res.frame_index      = frame_nxt;
  assign res.checkpoint_index = ncp9[cst_pkg::SLOT_W-1:0];
  assign res.finished         = done_rep;

  assign out_valid = (cnt_r != 2'd0);
  assign in_stall  = (cnt_r == 2'd2);
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (in_acc) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({in_acc, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      buf_r[wr_ptr_r] <= res;
    end
  end

  assign out_pulse            = buf_r[rd_ptr_r].pulse;
  assign out_frame_index      = buf_r[rd_ptr_r].frame_index;
  assign out_checkpoint_index = buf_r[rd_ptr_r].checkpoint_index;
  assign out_finished         = buf_r[rd_ptr_r].finished;

endmodule

`default_nettype wire
